/* hw/rtl/lsae_pkg.sv */
// Shared types and constants for the light sensor auto exposure block.
`default_nettype none
package lsae_pkg;

   localparam logic [7:0] TIME_MIN       = 8'd20;
   localparam logic [7:0] TIME_MID       = 8'd100;
   localparam logic [7:0] TIME_MAX       = 8'd200;
   localparam logic [7:0] BRIGHT_MIN     = 8'd20;
   localparam logic [7:0] BRIGHT_DEFAULT = 8'd128;
   localparam logic [7:0] BRIGHT_MAX     = 8'd255;
   localparam logic [7:0] TIME_STEP      = 8'd20;
   localparam logic [7:0] BRIGHT_OFFSET  = 8'h20;
   localparam logic [1:0] GAIN_TOP       = 2'd3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DARK_LIMIT     = 3'd0,
      CSR_INDOOR_LIMIT   = 3'd1,
      CSR_BRIGHT_LIMIT   = 3'd2,
      CSR_SIGNAL_FLOOR   = 3'd3,
      CSR_SIGNAL_CEILING = 3'd4,
      CSR_SETTLE_MS      = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ACT_HOLD      = 3'd0,
      ACT_NONE      = 3'd1,
      ACT_PRESET    = 3'd2,
      ACT_GAIN_DOWN = 3'd3,
      ACT_TIME_DOWN = 3'd4,
      ACT_TIME_UP   = 3'd5,
      ACT_GAIN_UP   = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      CLASS_DARK        = 2'd0,
      CLASS_INDOOR      = 2'd1,
      CLASS_BRIGHT      = 2'd2,
      CLASS_VERY_BRIGHT = 2'd3
   } light_class_type;

   typedef struct packed {
      logic [15:0] dark_limit;
      logic [15:0] indoor_limit;
      logic [15:0] bright_limit;
      logic [15:0] signal_floor;
      logic [15:0] signal_ceiling;
      logic [15:0] settle_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        sat_flag;
      logic [15:0] x_level;
      logic [15:0] y_level;
      logic [15:0] z_level;
   } req_item_type;

   typedef struct packed {
      logic [7:0] integration_time;
      logic [1:0] gain_code;
      logic [7:0] led_brightness;
      logic [1:0] light_class;
      action_type action;
   } rsp_item_type;

endpackage
`default_nettype wire

/* hw/rtl/lsae_req_if.sv */
// Measurement input channel.
`default_nettype none
interface lsae_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        sat_flag;
   logic [15:0] x_level;
   logic [15:0] y_level;
   logic [15:0] z_level;

   modport source(output valid, now_ms, sat_flag, x_level, y_level, z_level, input ready);
   modport sink(input valid, now_ms, sat_flag, x_level, y_level, z_level, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lsae_rsp_if.sv */
// Exposure result channel.
`default_nettype none
interface lsae_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] integration_time;
   logic [1:0] gain_code;
   logic [7:0] led_brightness;
   logic [1:0] light_class;
   logic [2:0] action;

   modport source(output valid, integration_time, gain_code, led_brightness, light_class,
                  action, input ready);
   modport sink(input valid, integration_time, gain_code, led_brightness, light_class,
                action, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lsae_csr_if.sv */
// Configuration register write channel.
`default_nettype none
interface lsae_csr_if;
   import lsae_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lsae_csr.sv */
// Configuration register file for the auto exposure block.
`default_nettype none
module lsae_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   lsae_csr_if.sink              csr_ch,
   output      lsae_pkg::cfg_type cfg
);
   import lsae_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_DARK_LIMIT:     cfg_in.dark_limit     = csr_ch.data;
            CSR_INDOOR_LIMIT:   cfg_in.indoor_limit   = csr_ch.data;
            CSR_BRIGHT_LIMIT:   cfg_in.bright_limit   = csr_ch.data;
            CSR_SIGNAL_FLOOR:   cfg_in.signal_floor   = csr_ch.data;
            CSR_SIGNAL_CEILING: cfg_in.signal_ceiling = csr_ch.data;
            CSR_SETTLE_MS:      cfg_in.settle_ms      = csr_ch.data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_limit     <= 16'd100;
         cfg_ff.indoor_limit   <= 16'd1000;
         cfg_ff.bright_limit   <= 16'd10000;
         cfg_ff.signal_floor   <= 16'd1000;
         cfg_ff.signal_ceiling <= 16'd60000;
         cfg_ff.settle_ms      <= 16'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/lsae_step.sv */
// Exposure state registers and the per-measurement decision logic.
`default_nettype none
module lsae_step (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire lsae_pkg::cfg_type      cfg,
   input  wire lsae_pkg::req_item_type item,
   output      lsae_pkg::rsp_item_type result
);
   import lsae_pkg::*;

   logic [7:0]  time_ff, time_in;
   logic [1:0]  gain_ff, gain_in;
   logic [7:0]  bright_ff, bright_in;
   logic [1:0]  class_ff, class_in;
   logic        preset_valid_ff, preset_valid_in;
   logic [31:0] last_change_ff, last_change_in;

   logic [31:0]     elapsed;
   logic            hold;
   light_class_type cls;
   logic            sat_any;
   logic            low_any;
   logic [8:0]      time_up_sum;
   action_type      act;

   assign elapsed = item.now_ms - last_change_ff;
   assign hold    = elapsed < {15'd0, cfg.settle_ms, 1'b0};
   assign sat_any = item.sat_flag || (item.x_level > cfg.signal_ceiling)
                    || (item.y_level > cfg.signal_ceiling)
                    || (item.z_level > cfg.signal_ceiling);
   assign low_any = (item.x_level <= cfg.signal_floor) || (item.y_level <= cfg.signal_floor)
                    || (item.z_level <= cfg.signal_floor);
   assign time_up_sum = {1'b0, time_ff} + {1'b0, TIME_STEP};

   always_comb begin
      if (item.y_level < cfg.dark_limit) begin
         cls = CLASS_DARK;
      end else if (item.y_level < cfg.indoor_limit) begin
         cls = CLASS_INDOOR;
      end else if (item.y_level < cfg.bright_limit) begin
         cls = CLASS_BRIGHT;
      end else begin
         cls = CLASS_VERY_BRIGHT;
      end
   end

   always_comb begin
      logic done;
      done            = 1'b0;
      act             = ACT_NONE;
      time_in         = time_ff;
      gain_in         = gain_ff;
      bright_in       = bright_ff;
      class_in        = class_ff;
      preset_valid_in = preset_valid_ff;
      last_change_in  = last_change_ff;
      if (hold) begin
         act = ACT_HOLD;
      end else begin
         if ((cls != light_class_type'(class_ff)) || !preset_valid_ff) begin
            case (cls)
               CLASS_DARK: begin
                  time_in = TIME_MAX; gain_in = 2'd3; bright_in = BRIGHT_MAX;
               end
               CLASS_INDOOR: begin
                  time_in = TIME_MID; gain_in = 2'd2; bright_in = BRIGHT_DEFAULT;
               end
               CLASS_BRIGHT: begin
                  time_in = TIME_MIN; gain_in = 2'd1; bright_in = BRIGHT_MIN + BRIGHT_OFFSET;
               end
               default: begin
                  time_in = TIME_MIN; gain_in = 2'd0; bright_in = BRIGHT_MIN;
               end
            endcase
            class_in        = cls;
            preset_valid_in = 1'b1;
            last_change_in  = item.now_ms;
            act             = ACT_PRESET;
            done            = 1'b1;
         end
         if (!done && sat_any) begin
            if (gain_ff != 2'd0) begin
               gain_in = gain_ff - 2'd1;
               act     = ACT_GAIN_DOWN;
               done    = 1'b1;
            end else if (time_ff > TIME_MIN) begin
               if ({1'b0, time_ff} >= ({1'b0, TIME_MIN} + {1'b0, TIME_STEP})) begin
                  time_in = time_ff - TIME_STEP;
               end else begin
                  time_in = TIME_MIN;
               end
               act  = ACT_TIME_DOWN;
               done = 1'b1;
            end
         end
         if (!done && low_any) begin
            if (time_ff < TIME_MAX) begin
               if (time_up_sum > {1'b0, TIME_MAX}) begin
                  time_in = TIME_MAX;
               end else begin
                  time_in = time_up_sum[7:0];
               end
               act = ACT_TIME_UP;
            end else if (gain_ff < GAIN_TOP) begin
               gain_in = gain_ff + 2'd1;
               act     = ACT_GAIN_UP;
            end
         end
      end
   end

   assign result.integration_time = time_in;
   assign result.gain_code        = gain_in;
   assign result.led_brightness   = bright_in;
   assign result.light_class      = class_in;
   assign result.action           = act;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff         <= TIME_MID;
         gain_ff         <= 2'd2;
         bright_ff       <= BRIGHT_DEFAULT;
         class_ff        <= CLASS_INDOOR;
         preset_valid_ff <= 1'b0;
         last_change_ff  <= 32'd0;
      end else if (enable) begin
         time_ff         <= time_in;
         gain_ff         <= gain_in;
         bright_ff       <= bright_in;
         class_ff        <= class_in;
         preset_valid_ff <= preset_valid_in;
         last_change_ff  <= last_change_in;
      end
   end

   a_gain_down_steps: assert property (@(posedge clock) disable iff (reset)
      enable && act == ACT_GAIN_DOWN |=> gain_ff == $past(gain_ff) - 2'd1)
      else $error("gain down did not lower gain by one");

   a_hold_keeps_state: assert property (@(posedge clock) disable iff (reset)
      enable && act == ACT_HOLD |=> $stable(time_ff) && $stable(gain_ff)
                                    && $stable(last_change_ff))
      else $error("held-off step changed settings");

   a_preset_marks_time: assert property (@(posedge clock) disable iff (reset)
      enable && act == ACT_PRESET |=> preset_valid_ff && last_change_ff == $past(item.now_ms))
      else $error("preset step did not record change time");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      time_ff >= TIME_MIN && time_ff <= TIME_MAX)
      else $error("integration time out of range");

endmodule
`default_nettype wire

/* hw/rtl/light_sensor_auto_exposure_top.sv */
// Light sensor auto exposure top level: input register, decision step, result register.
// A measurement is captured in the input register and its result in the result register,
// from which it transfers. Throughput: one measurement per cycle while results are taken;
// the state update completes in a single step.
// A stalled result register holds while one more measurement waits in the input register.
// Reset (synchronous): clears both pipeline stages and loads register and state defaults.
// Configuration writes take effect in the cycle after their transfer.
`default_nettype none
module light_sensor_auto_exposure_top (
   input wire logic clock,
   input wire logic reset,
   lsae_req_if.sink   req_ch,
   lsae_rsp_if.source rsp_ch,
   lsae_csr_if.sink   csr_ch
);
   import lsae_pkg::*;

   cfg_type      cfg;
   req_item_type s1_item_ff, s1_item_in;
   logic         s1_valid_ff, s1_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type step_result;
   logic         advance;
   logic         req_take;

   lsae_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr_ch(csr_ch),
      .cfg   (cfg)
   );

   lsae_step u_step (
      .clock (clock),
      .reset (reset),
      .enable(advance),
      .cfg   (cfg),
      .item  (s1_item_ff),
      .result(step_result)
   );

   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_item_in.now_ms   = req_ch.now_ms;
      s1_item_in.sat_flag = req_ch.sat_flag;
      s1_item_in.x_level  = req_ch.x_level;
      s1_item_in.y_level  = req_ch.y_level;
      s1_item_in.z_level  = req_ch.z_level;
      if (!req_take) begin
         s1_item_in = s1_item_ff;
      end
      s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_item_in  = advance ? step_result : out_item_ff;
      out_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.integration_time = out_item_ff.integration_time;
   assign rsp_ch.gain_code        = out_item_ff.gain_code;
   assign rsp_ch.led_brightness   = out_item_ff.led_brightness;
   assign rsp_ch.light_class      = out_item_ff.light_class;
   assign rsp_ch.action           = out_item_ff.action;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> out_valid_ff && $stable(out_item_ff))
      else $error("stalled result lost");

   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item produced no result");

   a_full_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input accepted with both stages full");

endmodule
`default_nettype wire

/* tb/sv/light_sensor_auto_exposure_top_tb.sv */
// Self-checking testbench for the light sensor auto exposure block.
`timescale 1ns / 1ps
module light_sensor_auto_exposure_top_tb;
   import lsae_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT    = 16;

   class exposure_scoreboard;
      cfg_type         cfg;
      logic [7:0]      time_now;
      logic [1:0]      gain_now;
      logic [7:0]      bright_now;
      light_class_type class_now;
      bit              preset_valid;
      logic [31:0]     last_change_ms;
      rsp_item_type    settings_due[$];
      int              mismatches;

      function new();
         cfg.dark_limit     = 16'd100;
         cfg.indoor_limit   = 16'd1000;
         cfg.bright_limit   = 16'd10000;
         cfg.signal_floor   = 16'd1000;
         cfg.signal_ceiling = 16'd60000;
         cfg.settle_ms      = 16'd50;
         time_now       = TIME_MID;
         gain_now       = 2'd2;
         bright_now     = BRIGHT_DEFAULT;
         class_now      = CLASS_INDOOR;
         preset_valid   = 1'b0;
         last_change_ms = '0;
         mismatches     = 0;
      endfunction

      function void note_config(csr_index_type idx, logic [15:0] v);
         case (idx)
            CSR_DARK_LIMIT:     cfg.dark_limit     = v;
            CSR_INDOOR_LIMIT:   cfg.indoor_limit   = v;
            CSR_BRIGHT_LIMIT:   cfg.bright_limit   = v;
            CSR_SIGNAL_FLOOR:   cfg.signal_floor   = v;
            CSR_SIGNAL_CEILING: cfg.signal_ceiling = v;
            CSR_SETTLE_MS:      cfg.settle_ms      = v;
            default: ;
         endcase
      endfunction

      function light_class_type classify(logic [15:0] y);
         if (y < cfg.dark_limit) return CLASS_DARK;
         if (y < cfg.indoor_limit) return CLASS_INDOOR;
         if (y < cfg.bright_limit) return CLASS_BRIGHT;
         return CLASS_VERY_BRIGHT;
      endfunction

      function void load_preset(light_class_type c);
         case (c)
            CLASS_DARK: begin
               time_now = TIME_MAX; gain_now = 2'd3; bright_now = BRIGHT_MAX;
            end
            CLASS_INDOOR: begin
               time_now = TIME_MID; gain_now = 2'd2; bright_now = BRIGHT_DEFAULT;
            end
            CLASS_BRIGHT: begin
               time_now = TIME_MIN; gain_now = 2'd1; bright_now = BRIGHT_MIN + BRIGHT_OFFSET;
            end
            default: begin
               time_now = TIME_MIN; gain_now = 2'd0; bright_now = BRIGHT_MIN;
            end
         endcase
         class_now    = c;
         preset_valid = 1'b1;
      endfunction

      function void note_measurement(req_item_type m);
         logic [31:0]     elapsed;
         logic [31:0]     hold_span;
         logic [8:0]      raised;
         light_class_type c;
         bit              done;
         bit              hot;
         bit              faint;
         action_type      act;
         rsp_item_type    r;
         elapsed   = m.now_ms - last_change_ms;
         hold_span = {15'd0, cfg.settle_ms, 1'b0};
         act       = ACT_NONE;
         if (elapsed < hold_span) begin
            act = ACT_HOLD;
         end else begin
            c     = classify(m.y_level);
            done  = 1'b0;
            hot   = m.sat_flag || m.x_level > cfg.signal_ceiling ||
                    m.y_level > cfg.signal_ceiling || m.z_level > cfg.signal_ceiling;
            faint = m.x_level <= cfg.signal_floor || m.y_level <= cfg.signal_floor ||
                    m.z_level <= cfg.signal_floor;
            if (c != class_now || !preset_valid) begin
               load_preset(c);
               last_change_ms = m.now_ms;
               act  = ACT_PRESET;
               done = 1'b1;
            end
            if (!done && hot) begin
               if (gain_now != 2'd0) begin
                  gain_now = gain_now - 2'd1;
                  act  = ACT_GAIN_DOWN;
                  done = 1'b1;
               end else if (time_now > TIME_MIN) begin
                  time_now = (time_now >= TIME_MIN + TIME_STEP) ? time_now - TIME_STEP
                                                                : TIME_MIN;
                  act  = ACT_TIME_DOWN;
                  done = 1'b1;
               end
            end
            if (!done && faint) begin
               if (time_now < TIME_MAX) begin
                  raised   = {1'b0, time_now} + {1'b0, TIME_STEP};
                  time_now = (raised > {1'b0, TIME_MAX}) ? TIME_MAX : raised[7:0];
                  act      = ACT_TIME_UP;
               end else if (gain_now < GAIN_TOP) begin
                  gain_now = gain_now + 2'd1;
                  act      = ACT_GAIN_UP;
               end
            end
         end
         r.integration_time = time_now;
         r.gain_code        = gain_now;
         r.led_brightness   = bright_now;
         r.light_class      = class_now;
         r.action           = act;
         settings_due.push_back(r);
      endfunction

      function void check_settings(rsp_item_type got);
         rsp_item_type want;
         if (settings_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result time %0d gain %0d led %0d class %0d action %0d",
                        $time, got.integration_time, got.gain_code, got.led_brightness,
                        got.light_class, got.action);
            return;
         end
         want = settings_due.pop_front();
         if (got.integration_time !== want.integration_time ||
             got.gain_code        !== want.gain_code ||
             got.led_brightness   !== want.led_brightness ||
             got.light_class      !== want.light_class ||
             got.action           !== want.action) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch exp time %0d gain %0d led %0d class %0d action %0d, %s",
                        $time, want.integration_time, want.gain_code, want.led_brightness,
                        want.light_class, want.action,
                        $sformatf("got time %0d gain %0d led %0d class %0d action %0d",
                                  got.integration_time, got.gain_code, got.led_brightness,
                                  got.light_class, got.action));
         end
      endfunction

      function int pending();
         return settings_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int   cycle_count;
   logic [31:0] stamp;
   exposure_scoreboard sb;

   lsae_req_if req_ch();
   lsae_rsp_if rsp_ch();
   lsae_csr_if csr_ch();

   light_sensor_auto_exposure_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_settings('{rsp_ch.integration_time, rsp_ch.gain_code, rsp_ch.led_brightness,
                             rsp_ch.light_class, action_type'(rsp_ch.action)});
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_measurement(input req_item_type m);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.now_ms   <= m.now_ms;
      req_ch.sat_flag <= m.sat_flag;
      req_ch.x_level  <= m.x_level;
      req_ch.y_level  <= m.y_level;
      req_ch.z_level  <= m.z_level;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_measurement(m);
      stamp = m.now_ms;
   endtask

   task automatic send_fields(input logic [31:0] now, input bit sat,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
      send_measurement('{now, sat, x, y, z});
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= v;
      do @(posedge clock); while (!csr_ch.ready);
      sb.note_config(idx, v);
   endtask

   task automatic write_config(input logic [15:0] dark, input logic [15:0] indoor,
                               input logic [15:0] bright, input logic [15:0] floor_v,
                               input logic [15:0] ceil_v, input logic [15:0] settle);
      write_register(CSR_DARK_LIMIT, dark);
      write_register(CSR_INDOOR_LIMIT, indoor);
      write_register(CSR_BRIGHT_LIMIT, bright);
      write_register(CSR_SIGNAL_FLOOR, floor_v);
      write_register(CSR_SIGNAL_CEILING, ceil_v);
      write_register(CSR_SETTLE_MS, settle);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic write_random_config(input bit ordered, input int settle_top);
      logic [15:0] a, b, c, t, f, g;
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      f = 16'($urandom);
      g = 16'($urandom);
      if (ordered) begin
         if (a > b) begin t = a; a = b; b = t; end
         if (b > c) begin t = b; b = c; c = t; end
         if (a > b) begin t = a; a = b; b = t; end
         if (f > g) begin t = f; f = g; g = t; end
      end
      write_config(a, b, c, f, g, 16'($urandom_range(0, settle_top)));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] clamp_level(input int v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
   endfunction

   function automatic logic [15:0] level_in_class(input int k);
      int lo;
      int hi;
      int d;
      int i;
      int b;
      d  = sb.cfg.dark_limit;
      i  = sb.cfg.indoor_limit;
      b  = sb.cfg.bright_limit;
      lo = 0;
      hi = 65536;
      case (k)
         0: hi = d;
         1: begin lo = d; hi = i; end
         2: begin lo = (d > i) ? d : i; hi = b; end
         default: begin lo = (d > i) ? d : i; lo = (lo > b) ? lo : b; end
      endcase
      if (lo >= hi) return 16'($urandom);
      case ($urandom_range(0, 3))
         0: return lo[15:0];
         1: return clamp_level(hi - 1);
         default: return clamp_level($urandom_range(lo, hi - 1));
      endcase
   endfunction

   function automatic logic [15:0] channel_level();
      int f;
      int g;
      f = sb.cfg.signal_floor;
      g = sb.cfg.signal_ceiling;
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return clamp_level(f + $urandom_range(0, 2) - 1);
         3: return clamp_level(g + $urandom_range(0, 2) - 1);
         4: return (f < g) ? clamp_level($urandom_range(f + 1, g)) : 16'($urandom);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] next_stamp();
      int hold;
      hold = 2 * int'(sb.cfg.settle_ms);
      case ($urandom_range(0, 9))
         0, 1, 2: return stamp + $urandom_range(0, hold);
         9: return $urandom;
         default: return stamp + hold + $urandom_range(0, 40);
      endcase
   endfunction

   task automatic drive_random(input int count);
      int left;
      int run_len;
      int cls;
      req_item_type m;
      left = count;
      while (left > 0) begin
         run_len = $urandom_range(3, 30);
         cls     = $urandom_range(0, 3);
         for (int n = 0; n < run_len && left > 0; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               m.now_ms   = $urandom_range(0, 1) ? $urandom : stamp + $urandom_range(0, 300);
               m.sat_flag = 1'($urandom_range(0, 1));
               m.x_level  = 16'($urandom);
               m.y_level  = 16'($urandom);
               m.z_level  = 16'($urandom);
            end else begin
               m.now_ms   = next_stamp();
               m.sat_flag = ($urandom_range(0, 3) == 0);
               m.x_level  = channel_level();
               m.y_level  = level_in_class(cls);
               m.z_level  = channel_level();
            end
            send_measurement(m);
            left--;
         end
      end
   endtask

   initial begin
      sb              = new();
      reset           = 1'b1;
      steady          = 1'b0;
      cycle_count     = 0;
      stamp           = '0;
      req_ch.valid    = 1'b0;
      req_ch.now_ms   = '0;
      req_ch.sat_flag = 1'b0;
      req_ch.x_level  = '0;
      req_ch.y_level  = '0;
      req_ch.z_level  = '0;
      rsp_ch.ready    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_DARK_LIMIT;
      csr_ch.data     = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hold-off from reset, first preset even for the reset class
      send_fields(32'd0, 1'b0, 16'd5000, 16'd500, 16'd5000);
      send_fields(32'd99, 1'b0, 16'd5000, 16'd500, 16'd5000);
      send_fields(32'd100, 1'b1, 16'd5000, 16'd500, 16'd5000);
      send_fields(32'd199, 1'b1, 16'd5000, 16'd500, 16'd5000);
      // saturation walks gain then time down to the minima
      send_fields(32'd200, 1'b1, 16'd5000, 16'd500, 16'd5000);
      send_fields(32'd201, 1'b0, 16'hFFFF, 16'd500, 16'd5000);
      send_fields(32'd202, 1'b1, 16'd5000, 16'd500, 16'd5000);
      send_fields(32'd203, 1'b1, 16'd5000, 16'd500, 16'd5000);
      send_fields(32'd204, 1'b1, 16'd5000, 16'd500, 16'd5000);
      send_fields(32'd205, 1'b1, 16'd5000, 16'd500, 16'd5000);
      send_fields(32'd206, 1'b1, 16'd5000, 16'd500, 16'd5000);
      // dark preset, then both bounds at the top
      send_fields(32'd207, 1'b0, 16'd5000, 16'd0, 16'd5000);
      send_fields(32'd306, 1'b0, 16'd0, 16'd0, 16'd0);
      send_fields(32'd307, 1'b0, 16'd0, 16'd0, 16'd0);
      send_fields(32'd308, 1'b1, 16'd0, 16'd0, 16'd0);
      send_fields(32'd309, 1'b0, 16'd0, 16'd0, 16'd0);
      // very bright preset and time stamp wrap
      send_fields(32'hFFFF_FF00, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_fields(32'h0000_0010, 1'b1, 16'hFFFF, 16'hFFFF, 16'd0);
      send_fields(32'h0000_0011, 1'b0, 16'd60001, 16'hFFFF, 16'd60000);
      send_fields(32'hFFFF_FF80, 1'b0, 16'd30000, 16'hFFFF, 16'd30000);
      send_fields(32'hFFFF_FF81, 1'b0, 16'd30000, 16'd5000, 16'd30000);
      send_fields(32'h7FFF_FFFF, 1'b0, 16'd1000, 16'd5000, 16'd1001);
      send_fields(32'h8000_0000, 1'b0, 16'd1001, 16'd9999, 16'd1001);
      send_fields(32'h8000_0001, 1'b0, 16'd1001, 16'd10000, 16'd1001);
      drive_random(220);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         steady = (phase == 2);
         case (phase)
            0: write_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            1: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: write_config(16'd100, 16'd1000, 16'd10000, 16'd1000, 16'd60000, 16'd50);
            3: write_random_config(1'b1, 0);
            7: write_random_config(1'b0, 65535);
            default: write_random_config(1'b1, 300);
         endcase
         drive_random(213);
         drain();
      end
      steady = 1'b0;

      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/lsae_pkg.sv
hw/rtl/lsae_req_if.sv
hw/rtl/lsae_rsp_if.sv
hw/rtl/lsae_csr_if.sv
hw/rtl/lsae_csr.sv
hw/rtl/lsae_step.sv
hw/rtl/light_sensor_auto_exposure_top.sv
tb/sv/light_sensor_auto_exposure_top_tb.sv
